// ===== src/kefd_pkg.sv =====
// Shared types, codes and the special key translation for the keyboard event FIFO device.
package kefd_pkg;

   typedef enum logic [2:0] {
      FUNC_KEY     = 3'd0,
      FUNC_TICK    = 3'd1,
      FUNC_CLEAR   = 3'd2,
      FUNC_GET     = 3'd3,
      FUNC_QUERY   = 3'd4,
      FUNC_SET_MSG = 3'd5
   } func_type;

   localparam int KEY_BITS  = 146;
   localparam int KEY_IDX_W = $clog2(KEY_BITS);

   localparam logic [8:0] ASCII_LO = 9'h020;
   localparam logic [8:0] ASCII_HI = 9'h07F;

   localparam logic [8:0] SYM_BACKSPACE = 9'd8;
   localparam logic [8:0] SYM_RETURN    = 9'd13;
   localparam logic [8:0] SYM_DELETE    = 9'd127;
   localparam logic [8:0] SYM_UP        = 9'd273;
   localparam logic [8:0] SYM_DOWN      = 9'd274;
   localparam logic [8:0] SYM_RIGHT     = 9'd275;
   localparam logic [8:0] SYM_LEFT      = 9'd276;
   localparam logic [8:0] SYM_INSERT    = 9'd277;
   localparam logic [8:0] SYM_RSHIFT    = 9'd303;
   localparam logic [8:0] SYM_LSHIFT    = 9'd304;
   localparam logic [8:0] SYM_RCTRL     = 9'd305;
   localparam logic [8:0] SYM_LCTRL     = 9'd306;

   localparam logic [7:0] CODE_NONE      = 8'h00;
   localparam logic [7:0] CODE_BACKSPACE = 8'h10;
   localparam logic [7:0] CODE_RETURN    = 8'h11;
   localparam logic [7:0] CODE_INSERT    = 8'h12;
   localparam logic [7:0] CODE_DELETE    = 8'h13;
   localparam logic [7:0] CODE_UP        = 8'h80;
   localparam logic [7:0] CODE_DOWN      = 8'h81;
   localparam logic [7:0] CODE_LEFT      = 8'h82;
   localparam logic [7:0] CODE_RIGHT     = 8'h84;
   localparam logic [7:0] CODE_SHIFT     = 8'h90;
   localparam logic [7:0] CODE_CTRL      = 8'h91;

   typedef struct packed {
      logic [2:0]  func;
      logic [8:0]  keysym;
      logic        key_down;
      logic [15:0] reg_b;
   } req_type;

   typedef struct packed {
      logic [15:0] c_value;
      logic        irq;
      logic [15:0] irq_message;
      logic        dropped;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctl_type;

   function automatic logic [7:0] map_special(input logic [8:0] sym);
      logic [7:0] code;
      unique case (sym)
         SYM_BACKSPACE: code = CODE_BACKSPACE;
         SYM_RETURN:    code = CODE_RETURN;
         SYM_INSERT:    code = CODE_INSERT;
         SYM_DELETE:    code = CODE_DELETE;
         SYM_UP:        code = CODE_UP;
         SYM_DOWN:      code = CODE_DOWN;
         SYM_LEFT:      code = CODE_LEFT;
         SYM_RIGHT:     code = CODE_RIGHT;
         SYM_RSHIFT:    code = CODE_SHIFT;
         SYM_LSHIFT:    code = CODE_SHIFT;
         SYM_RCTRL:     code = CODE_CTRL;
         SYM_LCTRL:     code = CODE_CTRL;
         default:       code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== src/kefd_event_fifo.sv =====
// Key code FIFO: storage array, pointers, fill count and registered read data.
module kefd_event_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  kefd_pkg::fifo_ctl_type          ctl,
   input  logic [7:0]                      push_code,
   output logic [$clog2(FIFO_DEPTH+1)-1:0] count,
   output logic [7:0]                      rd_code
);

   localparam int PtrW = $clog2(FIFO_DEPTH);
   localparam int CntW = $clog2(FIFO_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);

   logic [7:0]      mem_ff [FIFO_DEPTH];
   logic [7:0]      rd_code_ff;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      priority if (ctl.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
         count_in  = count_ff + CntW'(1);
      end else if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
         count_in  = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_code;
      end
      if (ctl.pop) begin
         rd_code_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign count   = count_ff;
   assign rd_code = rd_code_ff;

endmodule

// ===== src/keyboard_event_fifo_device.sv =====
// Keyboard event FIFO device top level: request decode, key state, tick interrupt and result.
//
// Takes one request beat per clock and returns exactly one result beat for each, through an
// input register and then a result register; a stalled result holds the pipeline and drops
// req_ready once the input register is full. Key events push translated codes into a
// FIFO_DEPTH x 8 bit array with one write and one read port, a pop taking the code into a read
// register that feeds the result. Pressed state lives in 146 flip-flops cleared by reset, so
// the block is ready as soon as reset is released; queries beyond them return 0. A tick raises
// irq with the stored message when the FIFO holds more codes than at the previous tick, and a
// zero message keeps interrupts disabled.
module keyboard_event_fifo_device #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kefd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kefd_pkg::rsp_type rsp_payload
);

   localparam int CntW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(FIFO_DEPTH);

   kefd_pkg::req_type       req_ff;
   logic                    req_valid_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             c_ff, c_in;
   logic                    irq_ff, irq_in;
   logic [15:0]             irq_msg_ff, irq_msg_in;
   logic                    drop_ff, drop_in;
   logic                    pop_sel_ff;
   logic [15:0]             int_msg_ff, int_msg_in;
   logic [CntW-1:0]         last_count_ff, last_count_in;
   logic [kefd_pkg::KEY_BITS-1:0] key_bits_ff, key_bits_in;

   logic                    advance;
   logic                    is_ascii;
   logic [7:0]              code;
   logic                    fifo_full;
   logic [CntW-1:0]         fifo_count;
   logic [7:0]              fifo_rd_code;
   kefd_pkg::fifo_ctl_type  fifo_ctl;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   assign is_ascii  = (req_ff.keysym >= kefd_pkg::ASCII_LO) &&
                      (req_ff.keysym <= kefd_pkg::ASCII_HI);
   assign code      = (is_ascii && req_ff.key_down) ? req_ff.keysym[7:0]
                                                    : kefd_pkg::map_special(req_ff.keysym);
   assign fifo_full = (fifo_count == FullCount);

   always_comb begin
      fifo_ctl      = '0;
      c_in          = '0;
      irq_in        = 1'b0;
      irq_msg_in    = '0;
      drop_in       = 1'b0;
      int_msg_in    = int_msg_ff;
      last_count_in = last_count_ff;
      key_bits_in   = key_bits_ff;
      unique case (req_ff.func)
         kefd_pkg::FUNC_KEY: begin
            if (is_ascii && !req_ff.key_down) begin
               key_bits_in[req_ff.keysym[kefd_pkg::KEY_IDX_W-1:0]] = 1'b0;
            end
            if (code != kefd_pkg::CODE_NONE) begin
               if (fifo_full) begin
                  drop_in = 1'b1;
               end else begin
                  fifo_ctl.push = advance;
                  key_bits_in[code[kefd_pkg::KEY_IDX_W-1:0]] = req_ff.key_down;
               end
            end
         end
         kefd_pkg::FUNC_TICK: begin
            if ((int_msg_ff != 16'h0000) && (fifo_count > last_count_ff)) begin
               irq_in     = 1'b1;
               irq_msg_in = int_msg_ff;
            end
            last_count_in = fifo_count;
         end
         kefd_pkg::FUNC_CLEAR: begin
            fifo_ctl.clear = advance;
         end
         kefd_pkg::FUNC_GET: begin
            fifo_ctl.pop = advance && (fifo_count != '0);
         end
         kefd_pkg::FUNC_QUERY: begin
            if (req_ff.reg_b < 16'(kefd_pkg::KEY_BITS)) begin
               c_in = {15'h0000, key_bits_ff[req_ff.reg_b[kefd_pkg::KEY_IDX_W-1:0]]};
            end
         end
         kefd_pkg::FUNC_SET_MSG: begin
            int_msg_in = req_ff.reg_b;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         int_msg_ff    <= '0;
         last_count_ff <= '0;
         key_bits_ff   <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            int_msg_ff    <= int_msg_in;
            last_count_ff <= last_count_in;
            key_bits_ff   <= key_bits_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff       <= c_in;
         irq_ff     <= irq_in;
         irq_msg_ff <= irq_msg_in;
         drop_ff    <= drop_in;
         pop_sel_ff <= fifo_ctl.pop;
      end
   end

   kefd_event_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_event_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fifo_ctl),
      .push_code(code),
      .count    (fifo_count),
      .rd_code  (fifo_rd_code)
   );

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_payload.c_value     = pop_sel_ff ? {8'h00, fifo_rd_code} : c_ff;
      rsp_payload.irq         = irq_ff;
      rsp_payload.irq_message = irq_msg_ff;
      rsp_payload.dropped     = drop_ff;
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= FullCount)
      else $error("fifo count beyond depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_ctl.pop |-> fifo_count != '0)
      else $error("pop on empty fifo");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      advance && drop_in |-> fifo_full && !fifo_ctl.push)
      else $error("drop without full fifo");

   a_irq_has_message: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && irq_ff |-> irq_msg_ff != 16'h0000)
      else $error("irq with zero message");

   a_stall_only_on_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("request stalled without result backpressure");
`endif

endmodule
